// File: hw/rtl/tcw_pkg.sv
// shared types, codes and control word layout of the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // field widths of the stream items
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CURSOR_W    = 11;
    localparam int COLOR_W     = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // micro program counter width
    localparam int UPC_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

    // configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_FORE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK = 1'b1;
    localparam logic [COLOR_W-1:0]     FORE_RESET = 4'hF;
    localparam logic [COLOR_W-1:0]     BACK_RESET = 4'h0;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CUR_ZERO,
        C_COL_ZERO,
        C_GLYPH_ZERO,
        C_CUR_OVER,
        C_PTR_LAST,
        C_PTR_MOVE_LAST,
        C_PTR_TAB_LAST
    } cond_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_DEC,
        CUR_ZERO,
        CUR_NEXTROW,
        CUR_LASTROW
    } cur_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        A_CUR,
        A_PTR,
        A_PTR_ROW,
        A_RIDX
    } asel_t;

    typedef enum logic [1:0] {
        W_ZERO,
        W_CHAR,
        W_MOVE
    } wsel_t;

    typedef struct packed {
        logic [UPC_W-1:0] target;
        cond_t            cond;
        logic             cond_neg;
        cur_op_t          cur_op;
        ptr_op_t          ptr_op;
        asel_t            asel;
        logic             wr_glyph;
        logic             wr_color;
        wsel_t            wsel;
        logic             set_scroll;
        logic             capture;
        logic             emit;
        logic             dispatch;
    } ucode_t;

    typedef struct packed {
        logic cur_zero;
        logic col_zero;
        logic glyph_zero;
        logic cur_over;
        logic ptr_last;
        logic ptr_move_last;
        logic ptr_tab_last;
    } flags_t;

    typedef struct packed {
        ucode_t cw;
        logic   step;
        logic   take;
    } seq_ctrl_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CHAR_W-1:0]   cell_char;
        logic [COLOR_W-1:0]  cell_fore;
        logic [COLOR_W-1:0]  cell_back;
        logic                scrolled;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_seq.sv
// microcode sequencer: program rom, step counter, dispatch and conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module tcw_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tcw_pkg::OP_W-1:0]    in_op,
    input  logic [tcw_pkg::CHAR_W-1:0]  in_char,
    input  tcw_pkg::flags_t             flags,
    input  logic                        out_busy,
    output tcw_pkg::seq_ctrl_t          ctrl
);

    import tcw_pkg::*;

    // program labels
    localparam logic [UPC_W-1:0] L_RST0  = 5'd0;
    localparam logic [UPC_W-1:0] L_RST1  = 5'd1;
    localparam logic [UPC_W-1:0] L_IDLE  = 5'd2;
    localparam logic [UPC_W-1:0] L_FIN   = 5'd3;
    localparam logic [UPC_W-1:0] L_CLR0  = 5'd4;
    localparam logic [UPC_W-1:0] L_CLR1  = 5'd5;
    localparam logic [UPC_W-1:0] L_RD0   = 5'd6;
    localparam logic [UPC_W-1:0] L_RD1   = 5'd7;
    localparam logic [UPC_W-1:0] L_BS0   = 5'd8;
    localparam logic [UPC_W-1:0] L_BS1   = 5'd9;
    localparam logic [UPC_W-1:0] L_BS2   = 5'd10;
    localparam logic [UPC_W-1:0] L_BS3   = 5'd11;
    localparam logic [UPC_W-1:0] L_BS4   = 5'd12;
    localparam logic [UPC_W-1:0] L_BSCLR = 5'd13;
    localparam logic [UPC_W-1:0] L_TAB   = 5'd14;
    localparam logic [UPC_W-1:0] L_CHK   = 5'd15;
    localparam logic [UPC_W-1:0] L_SC0   = 5'd16;
    localparam logic [UPC_W-1:0] L_SC1   = 5'd17;
    localparam logic [UPC_W-1:0] L_SC2   = 5'd18;
    localparam logic [UPC_W-1:0] L_SC3   = 5'd19;
    localparam logic [UPC_W-1:0] L_NL    = 5'd20;
    localparam logic [UPC_W-1:0] L_CHR   = 5'd21;

    function automatic ucode_t rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        w = '0;
        w.cond   = C_NEVER;
        w.cur_op = CUR_HOLD;
        w.ptr_op = PTR_HOLD;
        w.asel   = A_CUR;
        w.wsel   = W_ZERO;
        unique case (addr)
            // clearing pass after reset
            L_RST0:
            begin
                w.asel = A_PTR; w.wr_glyph = 1'b1; w.wr_color = 1'b1;
                w.ptr_op = PTR_INC;
                w.cond = C_PTR_LAST; w.cond_neg = 1'b1; w.target = L_RST0;
            end
            L_RST1:
            begin
                w.ptr_op = PTR_ZERO; w.cond = C_ALWAYS; w.target = L_IDLE;
            end
            L_IDLE:
            begin
                w.ptr_op = PTR_ZERO; w.dispatch = 1'b1;
            end
            L_FIN:
            begin
                w.emit = 1'b1; w.cond = C_ALWAYS; w.target = L_IDLE;
            end
            L_CLR0:
            begin
                w.asel = A_PTR; w.wr_glyph = 1'b1; w.wr_color = 1'b1;
                w.ptr_op = PTR_INC; w.cur_op = CUR_ZERO;
                w.cond = C_PTR_LAST; w.cond_neg = 1'b1; w.target = L_CLR0;
            end
            L_CLR1:
            begin
                w.cond = C_ALWAYS; w.target = L_FIN;
            end
            L_RD0:
            begin
                w.asel = A_RIDX;
            end
            L_RD1:
            begin
                w.capture = 1'b1; w.cond = C_ALWAYS; w.target = L_FIN;
            end
            L_BS0:
            begin
                w.cond = C_CUR_ZERO; w.target = L_FIN;
            end
            L_BS1:
            begin
                // mid-line: one step back, otherwise start the backward search
                w.cur_op = CUR_DEC;
                w.cond = C_COL_ZERO; w.cond_neg = 1'b1; w.target = L_BSCLR;
            end
            L_BS2:
            begin
                w.asel = A_CUR; w.cond = C_CUR_ZERO; w.target = L_BSCLR;
            end
            L_BS3:
            begin
                w.cond = C_GLYPH_ZERO; w.cond_neg = 1'b1; w.target = L_BSCLR;
            end
            L_BS4:
            begin
                w.cur_op = CUR_DEC; w.cond = C_ALWAYS; w.target = L_BS2;
            end
            L_BSCLR:
            begin
                w.asel = A_CUR; w.wr_glyph = 1'b1; w.wsel = W_ZERO;
                w.cond = C_ALWAYS; w.target = L_FIN;
            end
            L_TAB:
            begin
                w.cur_op = CUR_INC; w.ptr_op = PTR_INC;
                w.cond = C_PTR_TAB_LAST; w.cond_neg = 1'b1; w.target = L_TAB;
            end
            L_CHK:
            begin
                w.ptr_op = PTR_ZERO;
                w.cond = C_CUR_OVER; w.cond_neg = 1'b1; w.target = L_FIN;
            end
            L_SC0:
            begin
                w.asel = A_PTR_ROW; w.set_scroll = 1'b1;
            end
            L_SC1:
            begin
                w.asel = A_PTR; w.wr_glyph = 1'b1; w.wr_color = 1'b1;
                w.wsel = W_MOVE; w.ptr_op = PTR_INC;
                w.cond = C_PTR_MOVE_LAST; w.cond_neg = 1'b1; w.target = L_SC0;
            end
            L_SC2:
            begin
                w.asel = A_PTR; w.wr_glyph = 1'b1; w.wr_color = 1'b1;
                w.wsel = W_ZERO; w.ptr_op = PTR_INC;
                w.cond = C_PTR_LAST; w.cond_neg = 1'b1; w.target = L_SC2;
            end
            L_SC3:
            begin
                w.cur_op = CUR_LASTROW; w.cond = C_ALWAYS; w.target = L_FIN;
            end
            L_NL:
            begin
                w.cur_op = CUR_NEXTROW; w.cond = C_ALWAYS; w.target = L_CHK;
            end
            L_CHR:
            begin
                w.asel = A_CUR; w.wr_glyph = 1'b1; w.wr_color = 1'b1;
                w.wsel = W_CHAR; w.cur_op = CUR_INC;
                w.cond = C_ALWAYS; w.target = L_CHK;
            end
            default:
            begin
                w.cond = C_ALWAYS; w.target = L_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] entry;
    ucode_t           cw;
    logic             cond_raw;
    logic             stall;

    assign cw    = rom(upc_reg);
    assign stall = cw.emit && out_busy;

    // entry point of the program for the incoming request
    always_comb
    begin
        entry = L_FIN;
        unique case (in_op)
            OP_PUT:
            begin
                priority if (in_char == CH_NUL)       entry = L_FIN;
                else if (in_char == CH_BACKSPACE)     entry = L_BS0;
                else if (in_char == CH_TAB)           entry = L_TAB;
                else if (in_char == CH_NEWLINE)       entry = L_NL;
                else                                  entry = L_CHR;
            end
            OP_CLEAR: entry = L_CLR0;
            OP_READ:  entry = L_RD0;
            OP_NONE:  entry = L_FIN;
        endcase
    end

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:         cond_raw = 1'b0;
            C_ALWAYS:        cond_raw = 1'b1;
            C_CUR_ZERO:      cond_raw = flags.cur_zero;
            C_COL_ZERO:      cond_raw = flags.col_zero;
            C_GLYPH_ZERO:    cond_raw = flags.glyph_zero;
            C_CUR_OVER:      cond_raw = flags.cur_over;
            C_PTR_LAST:      cond_raw = flags.ptr_last;
            C_PTR_MOVE_LAST: cond_raw = flags.ptr_move_last;
            C_PTR_TAB_LAST:  cond_raw = flags.ptr_tab_last;
            default:         cond_raw = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (cw.dispatch)
        begin
            if (in_valid)
                upc_next = entry;
        end
        else if (!stall)
        begin
            if (cond_raw ^ cw.cond_neg)
                upc_next = cw.target;
            else
                upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= L_RST0;
        else
            upc_reg <= upc_next;
    end

    assign ctrl.cw   = cw;
    assign ctrl.step = !stall;
    assign ctrl.take = cw.dispatch && in_valid;

endmodule

`default_nettype wire

// File: hw/rtl/tcw_dpath.sv
// datapath: cell store, cursor and column, sweep pointer, request and result registers
`timescale 1ns / 1ps
`default_nettype none

module tcw_dpath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcw_pkg::seq_ctrl_t           ctrl,
    input  logic [tcw_pkg::CHAR_W-1:0]   in_char,
    input  logic [tcw_pkg::INDEX_W-1:0]  in_index,
    input  logic [tcw_pkg::COLOR_W-1:0]  fore_color,
    input  logic [tcw_pkg::COLOR_W-1:0]  back_color,
    output tcw_pkg::flags_t              flags,
    output tcw_pkg::result_t             result
);

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + TAB_STEP);
    localparam int COLW  = $clog2(COLUMNS);

    ucode_t cw;
    assign cw = ctrl.cw;

    logic [CW-1:0]      cur_reg;
    logic [CW-1:0]      cur_next;
    logic [COLW-1:0]    col_reg;
    logic [COLW-1:0]    col_next;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      ptr_next;
    logic [AW-1:0]      addr;
    logic [CHAR_W-1:0]  char_reg;
    logic [INDEX_W-1:0] ridx_reg;
    logic               ridx_ok_reg;
    logic [7:0]         glyph_rd_reg;
    logic [7:0]         color_rd_reg;
    logic [7:0]         wr_glyph_data;
    logic [7:0]         wr_color_data;
    logic [7:0]         res_char_reg;
    logic [7:0]         res_color_reg;
    logic               scroll_reg;

    logic [7:0] glyph_mem [CELLS];
    logic [7:0] color_mem [CELLS];

    // cursor with its column kept alongside, so no divide by the line length
    always_comb
    begin
        cur_next = cur_reg;
        col_next = col_reg;
        if (ctrl.step)
        begin
            unique case (cw.cur_op)
                CUR_HOLD: ;
                CUR_INC:
                begin
                    cur_next = cur_reg + 1'b1;
                    col_next = (col_reg == COLW'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                end
                CUR_DEC:
                begin
                    cur_next = cur_reg - 1'b1;
                    col_next = (col_reg == '0) ? COLW'(COLUMNS - 1) : col_reg - 1'b1;
                end
                CUR_ZERO:
                begin
                    cur_next = '0;
                    col_next = '0;
                end
                CUR_NEXTROW:
                begin
                    cur_next = cur_reg - CW'(col_reg) + CW'(COLUMNS);
                    col_next = '0;
                end
                CUR_LASTROW:
                begin
                    cur_next = CW'(CELLS - COLUMNS);
                    col_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctrl.step)
        begin
            unique case (cw.ptr_op)
                PTR_HOLD: ;
                PTR_ZERO: ptr_next = '0;
                PTR_INC:  ptr_next = ptr_reg + 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            col_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            col_reg <= col_next;
            ptr_reg <= ptr_next;
        end
    end

    always_comb
    begin
        unique case (cw.asel)
            A_CUR:     addr = AW'(cur_reg);
            A_PTR:     addr = ptr_reg;
            A_PTR_ROW: addr = ptr_reg + AW'(COLUMNS);
            A_RIDX:    addr = AW'(ridx_reg);
        endcase
    end

    always_comb
    begin
        unique case (cw.wsel)
            W_ZERO:
            begin
                wr_glyph_data = '0;
                wr_color_data = '0;
            end
            W_CHAR:
            begin
                wr_glyph_data = char_reg;
                wr_color_data = {back_color, fore_color};
            end
            W_MOVE:
            begin
                wr_glyph_data = glyph_rd_reg;
                wr_color_data = color_rd_reg;
            end
            default:
            begin
                wr_glyph_data = '0;
                wr_color_data = '0;
            end
        endcase
    end

    // cell store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.step && cw.wr_glyph)
            glyph_mem[addr] <= wr_glyph_data;
        if (ctrl.step && cw.wr_color)
            color_mem[addr] <= wr_color_data;
        glyph_rd_reg <= glyph_mem[addr];
        color_rd_reg <= color_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            char_reg    <= in_char;
            ridx_reg    <= in_index;
            ridx_ok_reg <= (32'(in_index) < 32'(CELLS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_char_reg  <= '0;
            res_color_reg <= '0;
            scroll_reg    <= 1'b0;
        end
        else if (ctrl.take)
        begin
            res_char_reg  <= '0;
            res_color_reg <= '0;
            scroll_reg    <= 1'b0;
        end
        else if (ctrl.step)
        begin
            // reads outside the store leave the cell fields at zero
            if (cw.capture && ridx_ok_reg)
            begin
                res_char_reg  <= glyph_rd_reg;
                res_color_reg <= color_rd_reg;
            end
            if (cw.set_scroll)
                scroll_reg <= 1'b1;
        end
    end

    assign flags.cur_zero      = (cur_reg == '0);
    assign flags.col_zero      = (col_reg == '0);
    assign flags.glyph_zero    = (glyph_rd_reg == '0);
    assign flags.cur_over      = (cur_reg >= CW'(CELLS));
    assign flags.ptr_last      = (ptr_reg == AW'(CELLS - 1));
    assign flags.ptr_move_last = (ptr_reg == AW'(CELLS - COLUMNS - 1));
    assign flags.ptr_tab_last  = (ptr_reg == AW'(TAB_STEP - 1));

    assign result.cursor    = CURSOR_W'(cur_reg);
    assign result.cell_char = res_char_reg;
    assign result.cell_fore = res_color_reg[3:0];
    assign result.cell_back = res_color_reg[7:4];
    assign result.scrolled  = scroll_reg;

endmodule

`default_nettype wire

// File: hw/rtl/text_console_writer.sv
// top level of the text console writer: stream ports, colour registers, result register
`timescale 1ns / 1ps
`default_nettype none

// Text console of COLUMNS x ROWS character cells (glyph byte plus colour byte) with a
// write cursor. A small microprogram walks a single-port cell store one access per
// cycle (it pauses only while a new result waits for the output register to free), so
// the cost of a request depends on what it does: NUL and the unused op touch no cell;
// a printable character writes one cell and a read reads one; tab advances the cursor
// by TAB_STEP; backspace does nothing at cell zero, erases the cell before the cursor
// mid-line, and from a line start searches back over empty cells, one read each, to
// the last non-empty cell or cell zero; clear writes every cell. A request that runs
// past the last cell also scrolls, with a read and a write on the one store port for
// each moved cell. After reset the store is cleared in a pass during which no request
// is taken; colour writes are accepted at any time. A finished result sits in an output
// register, so the next request can start while it waits to be taken.
module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_code [7:0], read_index [18:8]
    input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op [1:0]
    input  logic [tcw_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cursor_pos [10:0], cell_char [18:11], cell_fore [22:19], cell_back [26:23],
    // did_scroll [27]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import tcw_pkg::*;

    seq_ctrl_t ctrl;
    flags_t    flags;
    result_t   result;

    logic [COLOR_W-1:0]     fore_reg;
    logic [COLOR_W-1:0]     back_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_busy;
    logic                   emit;

    assign out_busy = out_valid_reg && !m_axis_tready;
    assign emit     = ctrl.step && ctrl.cw.emit;

    tcw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser[OP_W-1:0]),
        .in_char  (s_axis_tdata[CHAR_W-1:0]),
        .flags    (flags),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    tcw_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_char    (s_axis_tdata[CHAR_W-1:0]),
        .in_index   (s_axis_tdata[CHAR_W +: INDEX_W]),
        .fore_color (fore_reg),
        .back_color (back_reg),
        .flags      (flags),
        .result     (result)
    );

    assign s_axis_tready = ctrl.cw.dispatch;

    // colour registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg <= FORE_RESET;
            back_reg <= BACK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FORE: fore_reg <= cfg_data[COLOR_W-1:0];
                CFG_BACK: back_reg <= cfg_data[COLOR_W-1:0];
            endcase
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= {4'b0000, result.scrolled, result.cell_back,
                             result.cell_fore, result.cell_char, result.cursor};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tcw_checker.sv
// port-level checks of the text console writer and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;

    // a held result keeps its contents until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight: ready drops straight after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken back to back");

    // reported cursor always lies inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[10:0]) < 32'(CELLS))
        else $error("cursor outside the store");

    // a scroll leaves the cursor at the start of the last line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[10:0] == 11'(CELLS - COLUMNS))
        else $error("scroll left cursor off the last line start");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
